FILE: rtl/quantized_matvec_engine_macros.svh
// Assertion macros shared by the matvec engine RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef QUANTIZED_MATVEC_ENGINE_MACROS_SVH
`define QUANTIZED_MATVEC_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define QMV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define QMV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/qmv_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// quantized matvec engine. No dependencies.
package qmv_pkg;

  localparam int MAX_LEN   = 1024;
  localparam int MAX_ROWS  = 4096;
  localparam int LANES     = 4;

  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int ROW_IDX_W = $clog2(MAX_ROWS);
  localparam int ROWS_W    = $clog2(MAX_ROWS + 1);
  localparam int LANE_W    = $clog2(LANES);

  localparam int ACT_W     = 16;
  localparam int BYTE_W    = 8;
  localparam int WGT_W     = 8;
  localparam int CNT_W     = 3;
  localparam int PROD_W    = ACT_W + WGT_W;
  localparam int ACC_W     = 32;

  // input beat layout
  localparam int WGT_BASE   = LANES * ACT_W;
  localparam int LC_BASE    = WGT_BASE + LANES * WGT_W;
  localparam int IN_DATA_W  = ((LC_BASE + CNT_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ACC_W + ROW_IDX_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = ROWS_W;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_MODE   = 2'd2;

  // opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_WEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD,
    ST_READ,
    ST_MUL,
    ST_ACC
  } qmv_state_t;

  typedef struct packed {
    logic              capture;
    logic              load_step;
    logic              mul;
    logic              acc_step;
    logic [LANE_W-1:0] lane;
  } qmv_cmd_t;

  typedef struct packed {
    logic             opcode;
    logic [CNT_W-1:0] lanes;
    logic             load_end;
    logic             col_end;
    logic             out_free;
  } qmv_stat_t;

endpackage

FILE: rtl/qmv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qmv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/qmv_datapath.sv
// Datapath: config registers, item register, activation store, multiplier,
// accumulator, position counters and the result register. Uses qmv_pkg, qmv_ram.
`include "quantized_matvec_engine_macros.svh"

module qmv_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [qmv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qmv_pkg::CFG_W-1:0]        cfg_data,
  input  logic [qmv_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                             s_tuser,
  input  qmv_pkg::qmv_cmd_t                cmd,
  output qmv_pkg::qmv_stat_t               stat,
  output logic [qmv_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                             m_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready
);

  // configuration
  logic [qmv_pkg::LEN_W-1:0]  row_length;
  logic [qmv_pkg::ROWS_W-1:0] row_count;
  logic                       act_mode;
  logic [qmv_pkg::LEN_W-1:0]  len;
  logic [qmv_pkg::ROWS_W-1:0] rows;

  // captured item
  logic                       item_op;
  logic [qmv_pkg::ACT_W-1:0]  item_act [qmv_pkg::LANES];
  logic [qmv_pkg::WGT_W-1:0]  item_wgt [qmv_pkg::LANES];
  logic [qmv_pkg::CNT_W-1:0]  item_lanes;

  // pass state
  logic [qmv_pkg::ADDR_W-1:0]    load_pos;
  logic [qmv_pkg::ADDR_W-1:0]    col_pos;
  logic [qmv_pkg::ROW_IDX_W-1:0] row_pos;
  logic [qmv_pkg::ACC_W-1:0]     acc;
  logic [qmv_pkg::ACC_W-1:0]     acc_sum;
  logic signed [qmv_pkg::PROD_W-1:0] prod;
  logic signed [qmv_pkg::PROD_W-1:0] mul_res;

  logic [qmv_pkg::ACT_W-1:0]  act_sel;
  logic [qmv_pkg::ACT_W-1:0]  store_val;
  logic [qmv_pkg::ACT_W-1:0]  act_rd;
  logic [qmv_pkg::WGT_W-1:0]  wgt_sel;
  logic                       row_last;

  // result register
  logic [qmv_pkg::ACC_W-1:0]     out_sum;
  logic [qmv_pkg::ROW_IDX_W-1:0] out_idx;
  logic                          out_last;
  logic                          out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= qmv_pkg::LEN_W'(1);
      row_count  <= qmv_pkg::ROWS_W'(1);
      act_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qmv_pkg::CFG_ROW_LENGTH: row_length <= cfg_data[qmv_pkg::LEN_W-1:0];
        qmv_pkg::CFG_ROW_COUNT:  row_count  <= cfg_data[qmv_pkg::ROWS_W-1:0];
        qmv_pkg::CFG_ACT_MODE:   act_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize saturates
  always_comb begin
    if (row_length == '0) begin
      len = qmv_pkg::LEN_W'(1);
    end else if (row_length > qmv_pkg::LEN_W'(qmv_pkg::MAX_LEN)) begin
      len = qmv_pkg::LEN_W'(qmv_pkg::MAX_LEN);
    end else begin
      len = row_length;
    end
    if (row_count == '0) begin
      rows = qmv_pkg::ROWS_W'(1);
    end else if (row_count > qmv_pkg::ROWS_W'(qmv_pkg::MAX_ROWS)) begin
      rows = qmv_pkg::ROWS_W'(qmv_pkg::MAX_ROWS);
    end else begin
      rows = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_op    <= s_tuser;
      item_lanes <= s_tdata[qmv_pkg::LC_BASE +: qmv_pkg::CNT_W];
      for (int i = 0; i < qmv_pkg::LANES; i++) begin
        item_act[i] <= s_tdata[i*qmv_pkg::ACT_W +: qmv_pkg::ACT_W];
        item_wgt[i] <= s_tdata[qmv_pkg::WGT_BASE + i*qmv_pkg::WGT_W +: qmv_pkg::WGT_W];
      end
    end
  end

  assign act_sel = item_act[cmd.lane];
  assign wgt_sel = item_wgt[cmd.lane];

  // 8-bit mode keeps the sign-extended low byte
  assign store_val = act_mode ? act_sel
                   : {{(qmv_pkg::ACT_W-qmv_pkg::BYTE_W){act_sel[qmv_pkg::BYTE_W-1]}},
                      act_sel[qmv_pkg::BYTE_W-1:0]};

  qmv_ram #(
    .WIDTH (qmv_pkg::ACT_W),
    .DEPTH (qmv_pkg::MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load_step),
    .waddr (load_pos),
    .wdata (store_val),
    .raddr (col_pos),
    .rdata (act_rd)
  );

  assign mul_res = $signed(act_rd) * $signed(wgt_sel);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= mul_res;
    end
  end

  assign acc_sum = acc + {{(qmv_pkg::ACC_W-qmv_pkg::PROD_W){prod[qmv_pkg::PROD_W-1]}}, prod};

  assign stat.opcode   = item_op;
  assign stat.lanes    = (item_lanes > qmv_pkg::CNT_W'(qmv_pkg::LANES))
                         ? qmv_pkg::CNT_W'(qmv_pkg::LANES) : item_lanes;
  assign stat.load_end = (qmv_pkg::LEN_W'(load_pos) + qmv_pkg::LEN_W'(1)) >= len;
  assign stat.col_end  = (qmv_pkg::LEN_W'(col_pos) + qmv_pkg::LEN_W'(1)) >= len;
  assign stat.out_free = !out_valid || m_tready;
  assign row_last      = (qmv_pkg::ROWS_W'(row_pos) + qmv_pkg::ROWS_W'(1)) >= rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
      col_pos  <= '0;
      row_pos  <= '0;
      acc      <= '0;
    end else begin
      if (cmd.load_step) begin
        load_pos <= stat.load_end ? '0 : load_pos + qmv_pkg::ADDR_W'(1);
      end
      if (cmd.acc_step) begin
        if (stat.col_end) begin
          acc     <= '0;
          col_pos <= '0;
          row_pos <= row_last ? '0 : row_pos + qmv_pkg::ROW_IDX_W'(1);
        end else begin
          acc     <= acc_sum;
          col_pos <= col_pos + qmv_pkg::ADDR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.acc_step && stat.col_end) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_step && stat.col_end) begin
      out_sum  <= acc_sum;
      out_idx  <= row_pos;
      out_last <= row_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = qmv_pkg::OUT_DATA_W'({out_idx, out_sum});

  `QMV_ASSERT_NOW(a_row_end_needs_room, clk, rst, cmd.acc_step && stat.col_end, stat.out_free, "row result would overwrite a pending beat")
  `QMV_ASSERT_NEXT(a_acc_cleared, clk, rst, cmd.acc_step && stat.col_end, acc == '0, "accumulator not cleared after row end")
  `QMV_ASSERT_NOW(a_valid_source, clk, rst, $rose(m_tvalid), $past(cmd.acc_step && stat.col_end), "result beat without a row end")

endmodule

FILE: rtl/qmv_ctrl.sv
// Controller: sequences one item at a time, one lane per step, and drives
// the datapath through qmv_cmd_t. Uses qmv_pkg.
`include "quantized_matvec_engine_macros.svh"

module qmv_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  qmv_pkg::qmv_stat_t stat,
  output qmv_pkg::qmv_cmd_t  cmd
);

  qmv_pkg::qmv_state_t         state, state_next;
  logic [qmv_pkg::LANE_W-1:0]  lane, lane_next;
  logic                        lane_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qmv_pkg::ST_IDLE;
      lane  <= '0;
    end else begin
      state <= state_next;
      lane  <= lane_next;
    end
  end

  assign lane_last = (qmv_pkg::CNT_W'(lane) + qmv_pkg::CNT_W'(1)) == stat.lanes;

  always_comb begin
    state_next    = state;
    lane_next     = lane;
    s_tready      = 1'b0;
    cmd           = '0;
    cmd.lane      = lane;
    unique case (state)
      qmv_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          lane_next   = '0;
          state_next  = qmv_pkg::ST_DECODE;
        end
      end
      // store read of the current column is already in flight here
      qmv_pkg::ST_DECODE: begin
        if (stat.lanes == '0) begin
          state_next = qmv_pkg::ST_IDLE;
        end else if (stat.opcode == qmv_pkg::OP_LOAD) begin
          state_next = qmv_pkg::ST_LOAD;
        end else begin
          state_next = qmv_pkg::ST_MUL;
        end
      end
      qmv_pkg::ST_LOAD: begin
        cmd.load_step = 1'b1;
        if (stat.load_end || lane_last) begin
          state_next = qmv_pkg::ST_IDLE;
        end else begin
          lane_next = lane + qmv_pkg::LANE_W'(1);
        end
      end
      qmv_pkg::ST_READ: begin
        state_next = qmv_pkg::ST_MUL;
      end
      qmv_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = qmv_pkg::ST_ACC;
      end
      qmv_pkg::ST_ACC: begin
        if (stat.col_end) begin
          // wait for the result register to drain
          if (stat.out_free) begin
            cmd.acc_step = 1'b1;
            state_next   = qmv_pkg::ST_IDLE;
          end
        end else begin
          cmd.acc_step = 1'b1;
          if (lane_last) begin
            state_next = qmv_pkg::ST_IDLE;
          end else begin
            lane_next  = lane + qmv_pkg::LANE_W'(1);
            state_next = qmv_pkg::ST_READ;
          end
        end
      end
      default: state_next = qmv_pkg::ST_IDLE;
    endcase
  end

  `QMV_ASSERT_NOW(a_lane_in_range, clk, rst, state == qmv_pkg::ST_LOAD || state == qmv_pkg::ST_READ || state == qmv_pkg::ST_MUL || state == qmv_pkg::ST_ACC, qmv_pkg::CNT_W'(lane) < stat.lanes, "lane index past item lane count")
  `QMV_ASSERT_NOW(a_load_on_load_op, clk, rst, cmd.load_step, stat.opcode == qmv_pkg::OP_LOAD, "store write during a weight item")

endmodule

FILE: rtl/quantized_matvec_engine.sv
// Load item: one store write per lane after acceptance.
// Weight item: each lane passes through the store read, multiply and
// accumulate steps; a row result is valid the cycle after its last lane
// and may wait in the output register while new items are taken.
// Synchronous active-high reset clears positions and accumulator and sets
// config to a row length and count of one; activation store is not cleared.
module quantized_matvec_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [qmv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qmv_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // act_0..act_3, weight_0..weight_3, lane_count, zero pad
  input  logic [qmv_pkg::IN_DATA_W-1:0]     s_tdata,
  // opcode
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // row_sum, row_index, zero pad
  output logic [qmv_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tlast
);

  qmv_pkg::qmv_cmd_t  cmd;
  qmv_pkg::qmv_stat_t stat;

  qmv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  qmv_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready)
  );

endmodule
